// ----- hdl/tccw_pkg.sv -----
package tccw_pkg;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK,
        ST_CLEAR
    } state_t;

    // Input actions; the fourth code only reports the cursor.
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_COLUMNS    = 2'd0;
    localparam logic [1:0] REG_ROWS       = 2'd1;
    localparam logic [1:0] REG_TEXT_COLOR = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_BLANK   = 8'd32;
    localparam logic [7:0] TAB_STEP     = 8'd8;
    localparam logic [7:0] TAB_MASK     = 8'hF8;

    localparam logic [6:0] COLUMNS_RESET = 7'd80;
    localparam logic [4:0] ROWS_RESET    = 5'd25;
    localparam logic [7:0] COLOR_RESET   = 8'd7;
    localparam logic [15:0] INIT_CELL    = {COLOR_RESET, CHAR_BLANK};

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_position;
        logic        scrolled;
        logic [15:0] cell_data;
    } result_t;

endpackage

// ----- hdl/tccw_ram.sv -----
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/text_console_character_writer.sv -----
// Channel  Dir  Handshake          Contents
// s_       in   s_valid, s_ready   action, char_code, cell_index
// m_       out  m_valid, m_ready   cursor_col, cursor_row, cursor_position, scrolled, cell_data
// APB      in   psel, penable      columns at 0x0, rows at 0x4, text_color at 0x8
//
// A put without scroll and the unused action give their result straight from the idle state; a read
// gives its result from ST_READ, behind the registered read port of the cell memory.
// A clear writes every cell of the area in use, one cell write per cycle on the single write port.
// A put that scrolls does a read-then-write per copied cell, then
// one write per cell of the last row.
// After reset all MAX_ROWS*MAX_COLS cells (2000 at the defaults) of the cell memory are swept to
// blank in color 7, with s_ready low; configuration writes are taken throughout.
// One finished result may wait in a holding slot behind the output register; s_ready stays
// low while that slot is full.
module text_console_character_writer #(
    parameter int MAX_COLS = 80,
    parameter int MAX_ROWS = 25
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_char_code,
    input  logic [10:0] s_cell_index,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_cursor_col,
    output logic [4:0]  m_cursor_row,
    output logic [10:0] m_cursor_position,
    output logic        m_scrolled,
    output logic [15:0] m_cell_data,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import tccw_pkg::*;

    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam int AW         = $clog2(CELL_COUNT);

    state_t        state_reg, state_next;
    logic [6:0]    cols_reg;
    logic [4:0]    rows_reg;
    logic [7:0]    color_reg;
    logic [6:0]    cur_col_reg, cur_col_next;
    logic [4:0]    cur_row_reg, cur_row_next;
    logic [AW-1:0] base_reg, base_next;
    logic [6:0]    col_reg, col_next;
    logic [4:0]    row_reg, row_next;
    logic          copy_pend_reg, copy_pend_next;
    logic [AW-1:0] copy_dst_reg, copy_dst_next;
    logic          in_range_reg, in_range_next;
    logic          m_valid_reg;
    logic          pend_valid_reg;
    result_t       m_res_reg;
    result_t       pend_res_reg;

    logic [6:0]    nc;
    logic [4:0]    nr;
    logic [15:0]   blank;
    logic [AW-1:0] cell_addr;
    logic          last_col;
    logic          last_row;
    logic          s_accept;
    logic          cfg_write;

    logic [6:0]    col_sat;
    logic [4:0]    row_sat;
    logic [6:0]    col_inc;
    logic [7:0]    tab_col;
    logic [6:0]    put_col;
    logic          row_adv;
    logic [4:0]    put_row;
    logic          put_scroll;
    logic          put_writes;
    logic [AW-1:0] put_addr;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;

    logic          res_fire;
    logic          res_scrolled;
    logic [11:0]   pos_full;
    result_t       res;
    logic          out_free;

    tccw_ram #(
        .WIDTH (16),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_COLUMNS:    prdata = {25'd0, cols_reg};
            REG_ROWS:       prdata = {27'd0, rows_reg};
            REG_TEXT_COLOR: prdata = {24'd0, color_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // Effective area, saturated to the store.
    always_comb begin
        nc = cols_reg;
        if (cols_reg == 7'd0) begin
            nc = 7'd1;
        end else if (32'(cols_reg) > MAX_COLS) begin
            nc = 7'(MAX_COLS);
        end
        nr = rows_reg;
        if (rows_reg < 5'd2) begin
            nr = 5'd2;
        end else if (32'(rows_reg) > MAX_ROWS) begin
            nr = 5'(MAX_ROWS);
        end
    end

    assign blank     = {color_reg, CHAR_BLANK};
    assign cell_addr = base_reg + AW'(col_reg);
    assign last_col  = (col_reg == nc - 7'd1);
    assign last_row  = (row_reg == nr - 5'd1);
    assign s_ready   = (state_reg == ST_IDLE) && !pend_valid_reg;
    assign s_accept  = s_valid && s_ready;

    // Cursor step for a put, taken straight from the input.
    always_comb begin
        col_sat = (cur_col_reg >= nc) ? nc - 7'd1 : cur_col_reg;
        row_sat = (cur_row_reg >= nr) ? nr - 5'd1 : cur_row_reg;
        col_inc = col_sat + 7'd1;
        tab_col = ({1'b0, col_sat} + TAB_STEP) & TAB_MASK;
        put_writes = 1'b0;
        if (s_char_code == CHAR_NEWLINE) begin
            put_col = 7'd0;
            row_adv = 1'b1;
        end else if (s_char_code == CHAR_TAB) begin
            if (tab_col >= {1'b0, nc}) begin
                put_col = 7'd0;
                row_adv = 1'b1;
            end else begin
                put_col = tab_col[6:0];
                row_adv = 1'b0;
            end
        end else begin
            put_writes = 1'b1;
            if (col_inc >= nc) begin
                put_col = 7'd0;
                row_adv = 1'b1;
            end else begin
                put_col = col_inc;
                row_adv = 1'b0;
            end
        end
        put_row    = row_sat + {4'd0, row_adv};
        put_scroll = (put_row >= nr);
        put_addr   = AW'(32'(row_sat) * MAX_COLS + 32'(col_sat));
    end

    always_comb begin
        state_next     = state_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        base_next      = base_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        copy_pend_next = 1'b0;
        copy_dst_next  = copy_dst_reg;
        in_range_next  = in_range_reg;
        wr_en          = 1'b0;
        wr_addr        = cell_addr;
        wr_data        = blank;
        rd_en          = 1'b0;
        rd_addr        = cell_addr;
        res_fire       = 1'b0;
        res_scrolled   = 1'b0;

        unique case (state_reg)
            ST_INIT: begin
                wr_en   = 1'b1;
                wr_addr = base_reg;
                wr_data = INIT_CELL;
                if (base_reg == AW'(CELL_COUNT - 1)) begin
                    base_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    base_next = base_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (s_action)
                        ACT_PUT: begin
                            cur_col_next = put_col;
                            if (put_writes) begin
                                wr_en   = 1'b1;
                                wr_addr = put_addr;
                                wr_data = {color_reg, s_char_code};
                            end
                            if (put_scroll) begin
                                cur_row_next = nr - 5'd1;
                                base_next    = AW'(MAX_COLS);
                                col_next     = 7'd0;
                                row_next     = 5'd1;
                                state_next   = ST_COPY;
                            end else begin
                                cur_row_next = put_row;
                                res_fire     = 1'b1;
                            end
                        end
                        ACT_CLEAR: begin
                            cur_col_next = 7'd0;
                            cur_row_next = 5'd0;
                            base_next    = '0;
                            col_next     = 7'd0;
                            row_next     = 5'd0;
                            state_next   = ST_CLEAR;
                        end
                        ACT_READ: begin
                            rd_en         = 1'b1;
                            rd_addr       = AW'(s_cell_index);
                            in_range_next = (32'(s_cell_index) < CELL_COUNT);
                            state_next    = ST_READ;
                        end
                        default: begin
                            res_fire = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_fire   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_COPY: begin
                // Read one row below; the write lands one row up in the next cycle.
                rd_en          = 1'b1;
                copy_pend_next = 1'b1;
                copy_dst_next  = cell_addr - AW'(MAX_COLS);
                if (last_col) begin
                    col_next = 7'd0;
                    if (last_row) begin
                        state_next = ST_BLANK;
                    end else begin
                        row_next  = row_reg + 5'd1;
                        base_next = base_reg + AW'(MAX_COLS);
                    end
                end else begin
                    col_next = col_reg + 7'd1;
                end
            end
            ST_BLANK: begin
                if (!copy_pend_reg) begin
                    wr_en = 1'b1;
                    if (last_col) begin
                        col_next     = 7'd0;
                        res_fire     = 1'b1;
                        res_scrolled = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        col_next = col_reg + 7'd1;
                    end
                end
            end
            ST_CLEAR: begin
                wr_en = 1'b1;
                if (last_col) begin
                    col_next = 7'd0;
                    if (last_row) begin
                        res_fire   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        row_next  = row_reg + 5'd1;
                        base_next = base_reg + AW'(MAX_COLS);
                    end
                end else begin
                    col_next = col_reg + 7'd1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // The copy write of the previous cycle's read owns the write port.
        if (copy_pend_reg) begin
            wr_en   = 1'b1;
            wr_addr = copy_dst_reg;
            wr_data = rd_data;
        end
    end

    assign pos_full = 12'(cur_row_next) * 12'(nc) + 12'(cur_col_next);

    always_comb begin
        res.cursor_col      = cur_col_next;
        res.cursor_row      = cur_row_next;
        res.cursor_position = pos_full[10:0];
        res.scrolled        = res_scrolled;
        res.cell_data       = (state_reg == ST_READ && in_range_reg) ? rd_data : 16'd0;
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            cols_reg       <= COLUMNS_RESET;
            rows_reg       <= ROWS_RESET;
            color_reg      <= COLOR_RESET;
            cur_col_reg    <= 7'd0;
            cur_row_reg    <= 5'd0;
            base_reg       <= '0;
            col_reg        <= 7'd0;
            row_reg        <= 5'd0;
            copy_pend_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            base_reg      <= base_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            copy_pend_reg <= copy_pend_next;
            if (cfg_write) begin
                unique case (paddr[3:2])
                    REG_COLUMNS:    cols_reg  <= pwdata[6:0];
                    REG_ROWS:       rows_reg  <= pwdata[4:0];
                    REG_TEXT_COLOR: color_reg <= pwdata[7:0];
                    default: begin
                    end
                endcase
            end
            priority if (pend_valid_reg && out_free) begin
                m_valid_reg    <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (res_fire && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (res_fire) begin
                pend_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end else begin
                // The output register holds its transfer.
            end
        end
    end

    always_ff @(posedge aclk) begin
        copy_dst_reg <= copy_dst_next;
        in_range_reg <= in_range_next;
        priority if (pend_valid_reg && out_free) begin
            m_res_reg <= pend_res_reg;
        end else if (res_fire && out_free) begin
            m_res_reg <= res;
        end else if (res_fire) begin
            pend_res_reg <= res;
        end else begin
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_cursor_col      = m_res_reg.cursor_col;
    assign m_cursor_row      = m_res_reg.cursor_row;
    assign m_cursor_position = m_res_reg.cursor_position;
    assign m_scrolled        = m_res_reg.scrolled;
    assign m_cell_data       = m_res_reg.cell_data;

`ifndef NO_ASSERTIONS
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> m_valid_reg)
        else $error("Holding slot is full while the output register is empty.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |-> !pend_valid_reg)
        else $error("A result finished while the holding slot was still full.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY && copy_pend_reg) |-> (wr_addr != rd_addr))
        else $error("Scroll copy reads and writes the same cell in one cycle.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_action == ACT_PUT) |=> (cur_row_reg < $past(nr)))
        else $error("Cursor row left the area in use after a put.");
`endif

endmodule
